// File: hw/rtl/sfc_pkg.sv
// Shared types and constants of the SPI flash command controller.
package sfc_pkg;

    localparam int PAGE_BYTES    = 256;
    localparam int ADDRESS_BITS  = 24;
    localparam int ADDR_FIELD_W  = 24;
    localparam int ADDR_BYTES    = (ADDRESS_BITS + 7) / 8;
    localparam int ADDR_SPAN     = ADDR_BYTES * 8;
    localparam int HEADER_BYTES  = 1 + ADDR_BYTES;
    localparam int CMP_W         = (ADDR_SPAN > ADDR_FIELD_W) ? ADDR_SPAN : ADDR_FIELD_W;
    localparam int PAGE_AW       = $clog2(PAGE_BYTES);
    localparam int LP_W          = $clog2(PAGE_BYTES + 1);
    localparam int BI_W          = $clog2(HEADER_BYTES + PAGE_BYTES + 1);
    localparam int LEN_W         = 9;
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0] OP_PROGRAM  = 8'h02;
    localparam logic [7:0] OP_READ     = 8'h03;
    localparam logic [7:0] OP_STATUS   = 8'h05;
    localparam logic [7:0] OP_WREN     = 8'h06;
    localparam logic [7:0] OP_ERASE    = 8'h20;
    localparam logic [7:0] STATUS_BUSY = 8'h01;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;

    localparam logic [ADDR_FIELD_W-1:0] WINDOW_START_RESET = 24'h0FC000;
    localparam logic [ADDR_FIELD_W-1:0] WINDOW_END_RESET   = 24'h0FF000;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_LOAD    = 3'd1,
        CMD_READ    = 3'd2,
        CMD_PROGRAM = 3'd3,
        CMD_ERASE   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_PROGRAM = 2'd1,
        KIND_ERASE   = 2'd2
    } kind_t;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_WEN     = 6'b000010,
        PH_GAP_WEN = 6'b000100,
        PH_FRAME   = 6'b001000,
        PH_GAP_CMD = 6'b010000,
        PH_POLL    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic               en;
        logic [PAGE_AW-1:0] addr;
        logic [7:0]         data;
    } sfc_wr_t;

    typedef struct packed {
        logic       busy_res;
        logic       error;
        logic       done_res;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       clock_pulse;
        logic       mosi;
        logic       chip_selected;
    } sfc_result_t;

    typedef struct packed {
        logic [ADDR_FIELD_W-1:0] window_start;
        logic [ADDR_FIELD_W-1:0] window_end;
    } sfc_window_t;

endpackage

// File: hw/rtl/sfc_page_buf.sv
// Page buffer memory with per-entry valid bits and a registered read port.
module sfc_page_buf
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfc_pkg::sfc_wr_t            wr,
    input  logic [sfc_pkg::PAGE_AW-1:0] rd_addr,
    output logic [7:0]                  rd_data
);

    logic [7:0]                     mem [sfc_pkg::PAGE_BYTES];
    logic [sfc_pkg::PAGE_BYTES-1:0] valid_reg;
    logic [7:0]                     rd_data_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        rd_data_reg <= mem[rd_addr];
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule

// File: hw/rtl/sfc_engine.sv
// Command sequencer: frame state, bit serializer and per-item result logic.
module sfc_engine
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  sfc_pkg::cmd_t                    command,
    input  logic [sfc_pkg::ADDR_FIELD_W-1:0] address,
    input  logic [sfc_pkg::LEN_W-1:0]        length,
    input  logic [7:0]                       data,
    input  logic                             miso,
    input  sfc_pkg::sfc_window_t             window,
    input  logic [7:0]                       buf_data,
    output sfc_pkg::sfc_wr_t                 buf_wr,
    output logic [sfc_pkg::PAGE_AW-1:0]      buf_rd_addr,
    output sfc_pkg::sfc_result_t             result
);

    localparam logic [sfc_pkg::ADDR_SPAN-1:0] ADDR_MASK =
        sfc_pkg::ADDR_SPAN'((64'd1 << sfc_pkg::ADDRESS_BITS) - 64'd1);
    localparam logic [sfc_pkg::BI_W-1:0] HDR = sfc_pkg::BI_W'(sfc_pkg::HEADER_BYTES);
    localparam logic [sfc_pkg::LP_W-1:0] PAGE_FULL = sfc_pkg::LP_W'(sfc_pkg::PAGE_BYTES);

    sfc_pkg::phase_t                  phase_reg, phase_next;
    sfc_pkg::kind_t                   kind_reg, kind_next;
    logic [sfc_pkg::ADDR_SPAN-1:0]    addr_reg, addr_next;
    logic [sfc_pkg::LP_W-1:0]         tc_reg, tc_next;
    logic [sfc_pkg::LP_W-1:0]         lp_reg, lp_next;
    logic [sfc_pkg::BI_W-1:0]         bi_reg, bi_next;
    logic [2:0]                       bc_reg, bc_next;
    logic [7:0]                       tx_reg, tx_next;
    logic [7:0]                       rx_reg, rx_next;

    logic [7:0]                       frame_byte;
    logic [7:0]                       rx_shift;
    logic                             in_window;
    logic [sfc_pkg::CMP_W-1:0]        addr_cmp;
    logic [sfc_pkg::BI_W-1:0]         bi_rd;

    // byte to send for the current byte index
    always_comb
    begin
        frame_byte = 8'h00;
        if (phase_reg == sfc_pkg::PH_WEN)
            frame_byte = sfc_pkg::OP_WREN;
        else if (phase_reg == sfc_pkg::PH_POLL)
            frame_byte = (bi_reg == '0) ? sfc_pkg::OP_STATUS : 8'h00;
        else if (bi_reg == '0)
        begin
            unique case (kind_reg)
                sfc_pkg::KIND_READ:    frame_byte = sfc_pkg::OP_READ;
                sfc_pkg::KIND_PROGRAM: frame_byte = sfc_pkg::OP_PROGRAM;
                default:               frame_byte = sfc_pkg::OP_ERASE;
            endcase
        end
        else if (bi_reg < HDR)
        begin
            for (int j = 0; j < sfc_pkg::ADDR_BYTES; j++)
            begin
                if (bi_reg == sfc_pkg::BI_W'(j + 1))
                    frame_byte = addr_reg[8 * (sfc_pkg::ADDR_BYTES - 1 - j) +: 8];
            end
        end
        else
            frame_byte = buf_data;
    end

    assign addr_cmp  = sfc_pkg::CMP_W'(addr_reg);
    assign in_window = (addr_cmp >= sfc_pkg::CMP_W'(window.window_start)) &&
                       (addr_cmp <  sfc_pkg::CMP_W'(window.window_end));
    assign rx_shift  = {rx_reg[6:0], miso};

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        tc_next    = tc_reg;
        lp_next    = lp_reg;
        bi_next    = bi_reg;
        bc_next    = bc_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        buf_wr     = '0;
        result     = '0;

        if (command == sfc_pkg::CMD_TICK)
        begin
            unique case (phase_reg)
                sfc_pkg::PH_GAP_WEN:
                begin
                    phase_next = sfc_pkg::PH_FRAME;
                    bi_next    = '0;
                    bc_next    = 3'd7;
                end
                sfc_pkg::PH_GAP_CMD:
                begin
                    phase_next = sfc_pkg::PH_POLL;
                    bi_next    = '0;
                    bc_next    = 3'd7;
                end
                sfc_pkg::PH_WEN, sfc_pkg::PH_FRAME, sfc_pkg::PH_POLL:
                begin
                    result.chip_selected = 1'b1;
                    result.clock_pulse   = 1'b1;
                    tx_next              = (bc_reg == 3'd7) ? frame_byte : tx_reg;
                    result.mosi          = tx_next[bc_reg];
                    rx_next              = rx_shift;
                    if (bc_reg != 3'd0)
                        bc_next = bc_reg - 3'd1;
                    else
                    begin
                        bc_next = 3'd7;
                        if (phase_reg == sfc_pkg::PH_WEN)
                        begin
                            if (in_window)
                                phase_next = sfc_pkg::PH_GAP_WEN;
                            else
                            begin
                                phase_next      = sfc_pkg::PH_IDLE;
                                result.done_res = 1'b1;
                                result.error    = 1'b1;
                            end
                        end
                        else if (phase_reg == sfc_pkg::PH_FRAME)
                        begin
                            if (kind_reg == sfc_pkg::KIND_READ && bi_reg >= HDR)
                            begin
                                buf_wr.en       = 1'b1;
                                buf_wr.addr     = sfc_pkg::PAGE_AW'(bi_reg - HDR);
                                buf_wr.data     = rx_shift;
                                result.rx_byte  = rx_shift;
                                result.rx_valid = 1'b1;
                            end
                            if (bi_reg + 1'b1 >= HDR + sfc_pkg::BI_W'(tc_reg))
                            begin
                                if (kind_reg == sfc_pkg::KIND_READ)
                                begin
                                    phase_next      = sfc_pkg::PH_IDLE;
                                    result.done_res = 1'b1;
                                end
                                else
                                    phase_next = sfc_pkg::PH_GAP_CMD;
                            end
                            else
                                bi_next = bi_reg + 1'b1;
                        end
                        else
                        begin
                            // status poll: opcode byte, then the status byte
                            if (bi_reg == '0)
                                bi_next = sfc_pkg::BI_W'(1);
                            else if ((rx_shift & sfc_pkg::STATUS_BUSY) == 8'h00)
                            begin
                                phase_next      = sfc_pkg::PH_IDLE;
                                result.done_res = 1'b1;
                            end
                            else
                                bi_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg == sfc_pkg::PH_IDLE)
        begin
            unique case (command)
                sfc_pkg::CMD_LOAD:
                begin
                    if (lp_reg < PAGE_FULL)
                    begin
                        buf_wr.en   = 1'b1;
                        buf_wr.addr = lp_reg[sfc_pkg::PAGE_AW-1:0];
                        buf_wr.data = data;
                        lp_next     = lp_reg + 1'b1;
                    end
                end
                sfc_pkg::CMD_READ, sfc_pkg::CMD_PROGRAM, sfc_pkg::CMD_ERASE:
                begin
                    unique case (command)
                        sfc_pkg::CMD_READ:    kind_next = sfc_pkg::KIND_READ;
                        sfc_pkg::CMD_PROGRAM: kind_next = sfc_pkg::KIND_PROGRAM;
                        default:              kind_next = sfc_pkg::KIND_ERASE;
                    endcase
                    addr_next = sfc_pkg::ADDR_SPAN'(address) & ADDR_MASK;
                    if (command == sfc_pkg::CMD_ERASE)
                        tc_next = '0;
                    else if (32'(length) > sfc_pkg::PAGE_BYTES)
                        tc_next = PAGE_FULL;
                    else
                        tc_next = sfc_pkg::LP_W'(length);
                    bi_next    = '0;
                    bc_next    = 3'd7;
                    rx_next    = 8'h00;
                    tx_next    = 8'h00;
                    lp_next    = '0;
                    phase_next = (command == sfc_pkg::CMD_READ) ? sfc_pkg::PH_FRAME
                                                                : sfc_pkg::PH_WEN;
                end
                default:
                begin
                end
            endcase
        end

        if (command != sfc_pkg::CMD_TICK)
            result.chip_selected = (phase_next == sfc_pkg::PH_WEN) ||
                                   (phase_next == sfc_pkg::PH_FRAME) ||
                                   (phase_next == sfc_pkg::PH_POLL);
        result.busy_res = (phase_next != sfc_pkg::PH_IDLE);

        // drop writes of non-accepted items
        if (!accept)
            buf_wr.en = 1'b0;
    end

    // prefetch the page byte for the byte index that follows this cycle
    assign bi_rd       = accept ? bi_next : bi_reg;
    assign buf_rd_addr = sfc_pkg::PAGE_AW'(bi_rd - HDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfc_pkg::PH_IDLE;
            kind_reg  <= sfc_pkg::KIND_READ;
            addr_reg  <= '0;
            tc_reg    <= '0;
            lp_reg    <= '0;
            bi_reg    <= '0;
            bc_reg    <= 3'd7;
            tx_reg    <= 8'h00;
            rx_reg    <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            tc_reg    <= tc_next;
            lp_reg    <= lp_next;
            bi_reg    <= bi_next;
            bc_reg    <= bc_next;
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
        end
    end

endmodule

// File: hw/rtl/spi_flash_command_controller.sv
// SPI flash command controller for mode 0, one serial bit per tick item, with
// a page buffer loaded by load items. It takes one item per clock cycle: the
// sequencer updates its state at acceptance and the item's result is held in
// an output register, visible the cycle after acceptance, while the next item
// is already taken; input stalls only when that register is full and not
// taken. The page buffer is a single memory with one write port and a
// registered read that is prefetched from the next byte index, so a page byte
// is ready when its first bit is shifted out. The write window is set through
// the configuration port, index 0 for the start and 1 for the end address.
module spi_flash_command_controller
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // address[23:0], length[32:24], data[40:33], miso[41], zero[47:42]
    input  logic [47:0]                   s_tdata,
    // command[2:0]
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // chip_selected[0], mosi[1], clock_pulse[2], rx_byte[10:3], rx_valid[11],
    // done_res[12], error[13], busy_res[14], zero[15]
    output logic [15:0]                   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]                   cfg_data
);

    logic                          accept;
    sfc_pkg::sfc_window_t          window_reg;
    sfc_pkg::sfc_result_t          result;
    sfc_pkg::sfc_result_t          out_reg;
    logic                          out_valid_reg;
    sfc_pkg::sfc_wr_t              buf_wr;
    logic [sfc_pkg::PAGE_AW-1:0]   buf_rd_addr;
    logic [7:0]                    buf_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg.window_start <= sfc_pkg::WINDOW_START_RESET;
            window_reg.window_end   <= sfc_pkg::WINDOW_END_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == sfc_pkg::REG_WINDOW_START)
                window_reg.window_start <= cfg_data;
            else if (cfg_index == sfc_pkg::REG_WINDOW_END)
                window_reg.window_end <= cfg_data;
        end
    end

    sfc_page_buf u_page_buf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (buf_wr),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_data)
    );

    sfc_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (sfc_pkg::cmd_t'(s_tuser)),
        .address     (s_tdata[23:0]),
        .length      (s_tdata[32:24]),
        .data        (s_tdata[40:33]),
        .miso        (s_tdata[41]),
        .window      (window_reg),
        .buf_data    (buf_data),
        .buf_wr      (buf_wr),
        .buf_rd_addr (buf_rd_addr),
        .result      (result)
    );

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule
